// ----- sv/mcrm_pkg.sv -----
// mcrm_pkg: shared types and constants of the multi-channel rate meter.
// No dependencies; imported by mcrm_slot_table and the top level.
package mcrm_pkg;

  localparam int SLOT_W  = 5;
  localparam int SCALE_W = 10;
  localparam int RATE_W  = 26;
  localparam int ACT_W   = 2;

  localparam logic [ACT_W-1:0] ACT_REG   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_COUNT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_RATE  = 1'b1;

  localparam logic [RATE_W-1:0]  RATE_MAX    = {RATE_W{1'b1}};
  localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd5;

  // control from the sequencer to the slot table
  typedef struct packed {
    logic claim;       // mark the lowest free slot as used
    logic sweep_load;  // snapshot used flags into the sweep queue
    logic sweep_pop;   // drop the lowest pending slot
  } tbl_ctrl_t;

  // status from the slot table
  typedef struct packed {
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              any_used;
    logic              chan_used;
    logic              pend_any;
    logic [SLOT_W-1:0] pend_slot;
    logic              pend_last;
  } tbl_stat_t;

endpackage

// ----- sv/mcrm_count_ram.sv -----
// mcrm_count_ram: event counter store, one write and one read port,
// registered read data. No package dependency.
module mcrm_count_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/mcrm_slot_table.sv -----
// mcrm_slot_table: per-slot used flags, lowest-free search and the
// pending-slot queue walked by a tick sweep. Depends on mcrm_pkg.
module mcrm_slot_table #(
  parameter int SLOTS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mcrm_pkg::tbl_ctrl_t             ctrl,
  input  logic [mcrm_pkg::SLOT_W-1:0]     chan,
  output mcrm_pkg::tbl_stat_t             stat
);
  import mcrm_pkg::*;

  localparam int SIDX = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EXT  = 1 << SIDX;

  logic [SLOTS-1:0] used;
  logic [SLOTS-1:0] pend;
  logic [SLOTS-1:0] free_vec;
  logic [SLOTS-1:0] pend_low;
  logic [SLOTS-1:0] pend_rest;
  logic [EXT-1:0]   used_ext;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] pend_idx;

  // isolate lowest clear bit of used and lowest set bit of pend
  assign free_vec  = ~used & (used + SLOTS'(1));
  assign pend_low  = pend & (~pend + SLOTS'(1));
  assign pend_rest = pend & (pend - SLOTS'(1));
  assign used_ext  = EXT'(used);

  // one-hot to index: OR of set positions
  always_comb begin
    free_idx = '0;
    pend_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (free_vec[i]) begin
        free_idx = free_idx | SLOT_W'(i);
      end
      if (pend_low[i]) begin
        pend_idx = pend_idx | SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      pend <= '0;
    end else begin
      if (ctrl.claim) begin
        used <= used | free_vec;
      end
      if (ctrl.sweep_load) begin
        pend <= used;
      end else if (ctrl.sweep_pop) begin
        pend <= pend_rest;
      end
    end
  end

  always_comb begin
    stat.free_found = |free_vec;
    stat.free_slot  = free_idx;
    stat.any_used   = |used;
    stat.chan_used  = ({1'b0, chan} < (SLOT_W + 1)'(SLOTS)) && used_ext[chan[SIDX-1:0]];
    stat.pend_any   = |pend;
    stat.pend_slot  = pend_idx;
    stat.pend_last  = (pend_rest == '0);
  end

endmodule

// ----- sv/multi_channel_rate_meter_unit.sv -----
// multi_channel_rate_meter_unit: top level of the multi-channel rate meter.
// Depends on mcrm_pkg, mcrm_slot_table and mcrm_count_ram.
//
// Up to min(CHANNELS, 32) channel slots, each a used flag plus a saturating
// COUNT_BITS event counter kept in a one-port-write, one-port-read RAM. A
// register word (action 0) claims the lowest free slot and returns one reply
// word (slot, ok; ok=0 and slot 0 when full). A count word (action 1) bumps
// the counter of a registered channel and returns nothing; other channels
// are dropped. A tick word (action 2) walks the registered slots in
// ascending order and returns one rate word per slot, count * rate_scale
// saturated to 26 bits, with last set on the final one, clearing each
// counter. Action 3 is dropped. Register, count and tick-on-empty words
// are taken back to back; a register word right behind a count word waits
// while the count's read-modify-write owns the single write port of the
// counter RAM. A tick holds the input while each registered slot goes
// through a RAM read, a multiply step (which also writes the cleared
// counter) and an output step, which waits while the output is stalled.
// Any input word waits while a result sits stalled in the output register.
// No clearing pass is needed after reset: a counter is zeroed when its slot
// is claimed. rate_scale resets to 5 and is written through cfg_write and
// cfg_data; the user must do so only while the block is idle, as the block
// itself does not enforce it.
module multi_channel_rate_meter_unit #(
  parameter int CHANNELS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write,
  input  logic [mcrm_pkg::SCALE_W-1:0]    cfg_data,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mcrm_pkg::ACT_W-1:0]      action,
  input  logic [mcrm_pkg::SLOT_W-1:0]     channel,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            kind,
  output logic [mcrm_pkg::SLOT_W-1:0]     slot,
  output logic                            ok,
  output logic [mcrm_pkg::RATE_W-1:0]     rate,
  output logic                            last
);
  import mcrm_pkg::*;

  localparam int SLOTS = (CHANNELS < 32) ? CHANNELS : 32;
  localparam int SIDX  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW    = COUNT_BITS + SCALE_W;
  localparam int CW    = (PW > RATE_W) ? PW : RATE_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [SCALE_W-1:0] rate_scale;

  tbl_ctrl_t ctrl;
  tbl_stat_t stat;

  // counter RAM port signals
  logic                  we;
  logic [SIDX-1:0]       waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [SIDX-1:0]       raddr;
  logic [COUNT_BITS-1:0] rdata;

  // last write, for read-during-write forwarding
  logic                  wl_valid;
  logic [SIDX-1:0]       wl_addr;
  logic [COUNT_BITS-1:0] wl_data;

  // count read-modify-write stage
  logic                  cnt_valid;
  logic [SIDX-1:0]       cnt_addr;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_inc;

  // sweep slot in flight
  logic [SLOT_W-1:0]     cur_slot;
  logic                  cur_last;
  logic [PW-1:0]         prod;
  logic [RATE_W-1:0]     prod_sat;

  // output register load
  logic                  load_ok;
  logic                  load;
  logic                  ld_kind;
  logic [SLOT_W-1:0]     ld_slot;
  logic                  ld_ok;
  logic [RATE_W-1:0]     ld_rate;
  logic                  ld_last;

  logic                  in_acc;

  mcrm_slot_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk (clk),
    .rst (rst),
    .ctrl(ctrl),
    .chan(channel),
    .stat(stat)
  );

  mcrm_count_ram #(
    .DEPTH(SLOTS),
    .WIDTH(COUNT_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign load_ok = !out_valid || !out_stall;
  // a register word behind a count would collide on the RAM write port
  assign in_stall = (state != S_IDLE) || !load_ok || (cnt_valid && action == ACT_REG);
  assign in_acc = in_valid && !in_stall;

  // forward the write that landed on the same edge as our read
  assign cnt_cur = (wl_valid && wl_addr == cnt_addr) ? wl_data : rdata;
  assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

  assign prod_sat = (CW'(prod) > CW'(RATE_MAX)) ? RATE_MAX : RATE_W'(prod);

  always_comb begin
    ctrl       = '0;
    state_next = state;
    load       = 1'b0;
    ld_kind    = KIND_REPLY;
    ld_slot    = '0;
    ld_ok      = 1'b0;
    ld_rate    = '0;
    ld_last    = 1'b0;
    we         = 1'b0;
    waddr      = cnt_addr;
    wdata      = cnt_inc;
    raddr      = channel[SIDX-1:0];

    if (cnt_valid) begin
      we = 1'b1;
    end

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (action)
            ACT_REG: begin
              load       = 1'b1;
              ld_kind    = KIND_REPLY;
              ld_ok      = stat.free_found;
              ld_slot    = stat.free_found ? stat.free_slot : '0;
              ctrl.claim = stat.free_found;
              if (stat.free_found) begin
                we    = 1'b1;
                waddr = stat.free_slot[SIDX-1:0];
                wdata = '0;
              end
            end
            ACT_TICK: begin
              if (stat.any_used) begin
                ctrl.sweep_load = 1'b1;
                state_next      = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        raddr          = stat.pend_slot[SIDX-1:0];
        ctrl.sweep_pop = 1'b1;
        state_next     = S_MUL;
      end
      S_MUL: begin
        // counter is read; clear it now
        we         = 1'b1;
        waddr      = cur_slot[SIDX-1:0];
        wdata      = '0;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (load_ok) begin
          load       = 1'b1;
          ld_kind    = KIND_RATE;
          ld_slot    = cur_slot;
          ld_rate    = prod_sat;
          ld_last    = cur_last;
          state_next = cur_last ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rate_scale <= SCALE_RESET;
      cnt_valid  <= 1'b0;
      wl_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      cnt_valid <= in_acc && action == ACT_COUNT && stat.chan_used;
      wl_valid  <= we;
      if (cfg_write) begin
        rate_scale <= cfg_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_addr <= channel[SIDX-1:0];
    wl_addr  <= waddr;
    wl_data  <= wdata;
    if (state == S_READ) begin
      cur_slot <= stat.pend_slot;
      cur_last <= stat.pend_last;
    end
    if (state == S_MUL) begin
      prod <= PW'(rdata) * PW'(rate_scale);
    end
    if (load) begin
      kind <= ld_kind;
      slot <= ld_slot;
      ok   <= ld_ok;
      rate <= ld_rate;
      last <= ld_last;
    end
  end

  // the count stage never shares the write port with a sweep clear
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    cnt_valid |-> (state != S_MUL))
    else $error("count write overlaps sweep clear");

  // a sweep only reads while slots remain pending
  a_sweep_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> stat.pend_any)
    else $error("sweep read with empty queue");

  // the final rate word of a sweep returns the sequencer to idle
  a_last_ends_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && load_ok && cur_last) |=> (state == S_IDLE))
    else $error("sweep did not end after last word");

  // reply words carry no rate and no last mark
  a_reply_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_REPLY) |-> (rate == '0 && !last))
    else $error("reply word with rate or last set");

endmodule

// ----- dv/multi_channel_rate_meter_unit_tb.sv -----
// multi_channel_rate_meter_unit_tb: self-checking bench for the rate meter top level.
// Depends on mcrm_pkg and multi_channel_rate_meter_unit; predicts every result word
// with its own slot table and compares it against the DUT output in order.
module multi_channel_rate_meter_unit_tb;
  import mcrm_pkg::*;

  localparam int CHANNELS   = 32;
  localparam int COUNT_BITS = 16;
  // only the first min(CHANNELS, 32) slots exist
  localparam int NUM_SLOTS  = (CHANNELS < 32) ? CHANNELS : 32;
  localparam int CHAN_TOP   = (1 << SLOT_W) - 1;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;   // undefined action, dropped
  localparam logic [COUNT_BITS-1:0] HITS_MAX = '1;
  // settling time for drain(), covering a trailing count word
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int ERR_SHOWN     = 10;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [SLOT_W-1:0] chan;
  } cmd_word_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic [RATE_W-1:0] rate;
    logic              last;
  } meter_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [SCALE_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ACT_W-1:0]   action = '0;
  logic [SLOT_W-1:0]  channel = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               kind;
  logic [SLOT_W-1:0]  slot;
  logic               ok;
  logic [RATE_W-1:0]  rate;
  logic               last;

  multi_channel_rate_meter_unit #(
    .CHANNELS  (CHANNELS),
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .channel  (channel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind     (kind),
    .slot     (slot),
    .ok       (ok),
    .rate     (rate),
    .last     (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted meter state: used flags, window hit counters and the scale.
  // Updated at the edge where a word or a scale write is taken by the DUT.
  // ---------------------------------------------------------------------------
  logic                  slot_live [NUM_SLOTS];
  logic [COUNT_BITS-1:0] win_hits  [NUM_SLOTS];
  logic [SCALE_W-1:0]    scale_now = SCALE_RESET;

  meter_word_t pending_reports[$];  // result words still owed by the DUT
  cmd_word_t   queued_cmds[$];      // stimulus not yet presented

  int err_count = 0;
  int gen_regs  = 0;  // register words queued so far; slots 0..min(gen_regs, NUM_SLOTS)-1 get claimed

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_live[i] = 1'b0;
      win_hits[i]  = '0;
    end
  end

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= ERR_SHOWN) $display("%s", msg);
  endtask

  // Work out the result words one taken input word causes.
  task automatic predict_meter(input cmd_word_t w);
    meter_word_t       r;
    bit                found;
    int                top;
    longint unsigned   prod;
    r     = '0;
    found = 0;
    top   = -1;
    case (w.act)
      ACT_REG: begin
        // lowest free slot, or a full-table reply with slot 0
        r.kind = KIND_REPLY;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && !slot_live[i]) begin
            found        = 1;
            slot_live[i] = 1'b1;
            win_hits[i]  = '0;
            r.slot       = SLOT_W'(i);
            r.ok         = 1'b1;
          end
        end
        pending_reports.push_back(r);
      end
      ACT_COUNT: begin
        // unregistered slots drop the event; counters stick at all ones
        if (int'(w.chan) < NUM_SLOTS && slot_live[w.chan] && win_hits[w.chan] != HITS_MAX)
          win_hits[w.chan] = win_hits[w.chan] + 1'b1;
      end
      ACT_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_live[i]) top = i;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_live[i]) begin
            prod   = longint'(win_hits[i]) * longint'(scale_now);
            r      = '0;
            r.kind = KIND_RATE;
            r.slot = SLOT_W'(i);
            r.rate = (prod > longint'(RATE_MAX)) ? RATE_MAX : prod[RATE_W-1:0];
            r.last = (i == top);
            pending_reports.push_back(r);
            win_hits[i] = '0;
          end
        end
      end
      default: ;  // undefined action: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge.
  // word_taken tells the driver, at the next falling edge, that its word went in.
  // ---------------------------------------------------------------------------
  logic word_taken = 1'b0;

  always @(posedge clk) begin
    meter_word_t got;
    meter_word_t want;
    word_taken <= !rst && in_valid && !in_stall;
    if (!rst && cfg_write) scale_now = cfg_data;
    if (!rst && in_valid && !in_stall) predict_meter({action, channel});
    if (!rst && out_valid && !out_stall) begin
      got = {kind, slot, ok, rate, last};
      if (pending_reports.size() == 0) begin
        flag_error($sformatf("unexpected word: kind=%0d slot=%0d ok=%0d rate=%0d last=%0d",
                             kind, slot, ok, rate, last));
      end else begin
        want = pending_reports.pop_front();
        if (got.kind !== want.kind || got.slot !== want.slot || got.ok !== want.ok ||
            got.rate !== want.rate || got.last !== want.last)
          flag_error($sformatf({"mismatch: expected kind=%0d slot=%0d ok=%0d rate=%0d ",
                                "last=%0d, got kind=%0d slot=%0d ok=%0d rate=%0d last=%0d"},
                               want.kind, want.slot, want.ok, want.rate, want.last,
                               got.kind, got.slot, got.ok, got.rate, got.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them. A word stays
  // up, unchanged, until taken; the next one goes up on the same falling edge unless a gap is due.
  // ---------------------------------------------------------------------------
  int burst_left  = 0;
  int gap_left    = 0;
  int drv_gap_max = 6;

  always @(negedge clk) begin
    logic      nv;
    cmd_word_t w;
    nv = in_valid && !word_taken;
    w  = {action, channel};
    if (!nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (queued_cmds.size() != 0) begin
        w  = queued_cmds.pop_front();
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(24, 1);
          gap_left   = $urandom_range(drv_gap_max, 0);
        end
      end
    end
    in_valid <= nv;
    action   <= w.act;
    channel  <= w.chan;
  end

  // Receiver back-pressure: modes of random length - open, light, heavy, periodic.
  int stall_mode = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    bit s;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3, 0);
      stall_left = $urandom_range(80, 20);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       s = 1'b0;
      1:       s = ($urandom_range(99, 0) < 25);
      2:       s = ($urandom_range(99, 0) < 70);
      default: s = ((stall_left % 8) < 5);
    endcase
    out_stall <= s;
  end

  // Hard stop in case the DUT hangs.
  int cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("multi_channel_rate_meter_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input logic [ACT_W-1:0] a, input logic [SLOT_W-1:0] c);
    cmd_word_t w;
    w.act  = a;
    w.chan = c;
    queued_cmds.push_back(w);
    if (a == ACT_REG) gen_regs++;
  endtask

  // Mostly counts to claimed slots, with registers, ticks and some noise.
  task automatic push_random(input int n, input int reg_pct, input int tick_pct);
    int roll;
    int live;
    repeat (n) begin
      live = (gen_regs > NUM_SLOTS) ? NUM_SLOTS : gen_regs;
      roll = $urandom_range(99, 0);
      if (roll < reg_pct)
        push_cmd(ACT_REG, SLOT_W'($urandom_range(CHAN_TOP, 0)));
      else if (roll < reg_pct + tick_pct)
        push_cmd(ACT_TICK, SLOT_W'($urandom_range(CHAN_TOP, 0)));
      else if (roll < reg_pct + tick_pct + 4)
        push_cmd(ACT_UNUSED, SLOT_W'($urandom_range(CHAN_TOP, 0)));
      else if (roll < reg_pct + tick_pct + 12 || live == 0)
        push_cmd(ACT_COUNT, SLOT_W'($urandom_range(CHAN_TOP, 0)));  // may hit a free slot
      else
        push_cmd(ACT_COUNT, SLOT_W'($urandom_range(live - 1, 0)));
    end
  endtask

  // Scale writes go in only while the block is idle.
  task automatic write_scale(input logic [SCALE_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait for every word to be taken and every result to arrive, then let
  // any trailing read-modify-write finish.
  task automatic drain();
    while (queued_cmds.size() != 0 || in_valid || pending_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset scale: empty-table tick, dropped actions,
    // counts to free slots, first claims and small sweeps.
    push_cmd(ACT_TICK,   '0);
    push_cmd(ACT_UNUSED, SLOT_W'(CHAN_TOP));
    push_cmd(ACT_COUNT,  '0);
    push_cmd(ACT_COUNT,  SLOT_W'(CHAN_TOP));
    push_cmd(ACT_REG,    SLOT_W'(CHAN_TOP));
    push_cmd(ACT_COUNT,  '0);
    push_cmd(ACT_COUNT,  '0);
    push_cmd(ACT_COUNT,  '0);
    push_cmd(ACT_COUNT,  SLOT_W'(CHAN_TOP));
    push_cmd(ACT_TICK,   SLOT_W'(CHAN_TOP));
    push_cmd(ACT_TICK,   '0);                 // counter cleared by the last sweep
    push_cmd(ACT_REG,    '0);
    push_cmd(ACT_COUNT,  5'd1);               // count right behind a claim
    push_cmd(ACT_REG,    '0);                 // claim right behind a count
    push_cmd(ACT_COUNT,  5'd2);
    push_cmd(ACT_COUNT,  5'd2);
    push_cmd(ACT_UNUSED, '0);
    push_cmd(ACT_TICK,   '0);
    drain();

    // Scale 1000, a long run of counts to one slot with a few to slot 1.
    write_scale(10'd1000);
    drv_gap_max = 1;
    push_cmd(ACT_REG, '0);                    // slot 3
    for (int k = 0; k < 40; k++) begin
      push_cmd(ACT_COUNT, 5'd3);
      if (k % 16 == 0) push_cmd(ACT_COUNT, 5'd1);
    end
    push_cmd(ACT_TICK, '0);
    drain();

    drv_gap_max = 6;
    write_scale(10'd1);
    push_random(60, 10, 8);
    drain();

    write_scale(SCALE_W'($urandom_range(1000, 1)));
    push_random(60, 15, 4);
    drain();

    // Fill the table, then keep asking for slots that are not there.
    write_scale(10'd1000);
    while (gen_regs < NUM_SLOTS + 2) push_cmd(ACT_REG, SLOT_W'($urandom_range(CHAN_TOP, 0)));
    push_random(60, 5, 6);
    drain();

    write_scale(SCALE_W'($urandom_range(1000, 1)));
    drv_gap_max = 12;
    push_random(60, 8, 10);
    drain();

    if (pending_reports.size() != 0)
      flag_error($sformatf("%0d result words never arrived", pending_reports.size()));
    if (err_count == 0)
      $display("multi_channel_rate_meter_unit regression: pass");
    else
      $display("multi_channel_rate_meter_unit regression: fail");
    $finish;
  end

endmodule
